/* rtl/ssd_pkg.sv */
// Shared types and constants for the stereo sweep delay.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`timescale 1ns / 1ps

package ssd_pkg;

  // configuration register indexes
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] REG_DELAY_FRAMES = 1'b0;
  localparam logic [CFG_AW-1:0] REG_DELAY_GAIN   = 1'b1;

  localparam logic [15:0] DELAY_RESET = 16'd1000;
  localparam logic [15:0] GAIN_RESET  = 16'd16384;

  // scaling: d = floor((s*w*g + ROUND) / (2^16 * DIV_BY))
  localparam int ROUND  = 3276800;
  localparam int DIV_BY = 100;

  // pan position in hundredths, -1..101
  typedef logic signed [7:0] weight_t;
  localparam weight_t PAN_FULL = 8'sd100;

  // output queue and credit counting
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  typedef logic [FIFO_AW:0] cnt_t;

  // frames accepted but not yet written back (stage 0 plus four lane stages)
  typedef logic [2:0] flight_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ring_ctl_t;

endpackage

/* rtl/stereo_sweep_delay_core.sv */
// Top level of the stereo feedback delay with sweeping pan.
// Depends on ssd_pkg, ssd_ring, ssd_lane (left and right) and ssd_merge.
//
//   channel | ports                               | payload
//   --------+-------------------------------------+--------------------------------
//   input   | in_tvalid in_tready in_tdata in_tlast     | left_in, right_in; period_end
//   output  | out_tvalid out_tready out_tdata out_tlast | left_out, right_out; last_out
//   config  | cfg_valid cfg_ready cfg_index cfg_data    | 0 delay_frames, 1 delay_gain
//
// One frame per cycle sustained unless one of the waits below holds the input.
// When delay_frames mod RING_FRAMES is 1..5 a frame waits until the frame it reads
// has been written back from the merge stage, so at most that many frames are in flight.
// An 8-entry output queue with credit admits up to 8 unsent frames while out_tready is low.
// Reset is synchronous; the ring is not swept: a fill pointer makes unwritten slots read zero.
`timescale 1ns / 1ps

module stereo_sweep_delay_core #(
  parameter int RING_FRAMES = 65536,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       in_tdata,   // left_in, right_in
  input  logic                                     in_tlast,   // period_end
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       out_tdata,  // left_out, right_out
  output logic                                     out_tlast,  // last_out
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [ssd_pkg::CFG_AW-1:0]               cfg_index,
  input  logic [15:0]                              cfg_data
);

  localparam int AW = $clog2(RING_FRAMES);
  localparam int SB = SAMPLE_BITS;
  localparam int DW = ((2*SAMPLE_BITS+7)/8)*8;

  logic [15:0]          delay_r, gain_r;
  logic [AW-1:0]        wp_r;
  ssd_pkg::weight_t     pan_r, pan_nxt;
  logic                 fall_r, fall_nxt;
  ssd_pkg::flight_t     flight_r, flight_nxt;
  ssd_pkg::cnt_t        pend_r, pend_nxt;
  logic [4:0]           v_r, last_r;
  logic signed [SB-1:0] dryl_r, dryr_r;
  ssd_pkg::weight_t     wl_r, wr_r;

  logic [AW+15:0]       dly_ext;
  logic [AW-1:0]        gap, rd_addr;
  logic                 hazard_ok, accept, wb, out_xfer;
  ssd_pkg::ring_ctl_t   ring_ctl;
  logic signed [SB-1:0] wet_l, wet_r, sat_l, sat_r;
  logic signed [SB-1:0] dry_l4, dry_r4;
  logic signed [SB+1:0] d_l, d_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= ssd_pkg::DELAY_RESET;
      gain_r  <= ssd_pkg::GAIN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ssd_pkg::REG_DELAY_FRAMES: delay_r <= cfg_data;
        ssd_pkg::REG_DELAY_GAIN:   gain_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // distance back in the ring, modulo its length
  assign dly_ext = (AW+16)'(delay_r);
  assign gap     = dly_ext[AW-1:0];
  assign rd_addr = wp_r - gap;

  // the frame being read must already be in the ring, not still in the lanes
  assign hazard_ok = (gap == '0) || (AW'(flight_r) < gap);
  assign in_tready = (pend_r < ssd_pkg::cnt_t'(ssd_pkg::FIFO_DEPTH)) && hazard_ok;
  assign accept    = in_tvalid && in_tready;
  assign wb        = v_r[4];
  assign out_xfer  = out_tvalid && out_tready;

  always_comb begin
    unique case ({accept, wb})
      2'b10:   flight_nxt = flight_r + ssd_pkg::flight_t'(1);
      2'b01:   flight_nxt = flight_r - ssd_pkg::flight_t'(1);
      default: flight_nxt = flight_r;
    endcase
    unique case ({accept, out_xfer})
      2'b10:   pend_nxt = pend_r + ssd_pkg::cnt_t'(1);
      2'b01:   pend_nxt = pend_r - ssd_pkg::cnt_t'(1);
      default: pend_nxt = pend_r;
    endcase
  end

  // pan moves after the frame that ends a period; it turns once past either end
  always_comb begin
    pan_nxt  = pan_r;
    fall_nxt = fall_r;
    if (accept && in_tlast) begin
      if (!fall_r) begin
        pan_nxt = pan_r + ssd_pkg::weight_t'(1);
        if (pan_nxt > ssd_pkg::PAN_FULL) begin
          fall_nxt = 1'b1;
        end
      end else begin
        pan_nxt = pan_r - ssd_pkg::weight_t'(1);
        if (pan_nxt[7]) begin
          fall_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      pan_r    <= '0;
      fall_r   <= 1'b0;
      flight_r <= '0;
      pend_r   <= '0;
      v_r      <= '0;
    end else begin
      if (accept) begin
        wp_r <= wp_r + AW'(1);
      end
      pan_r    <= pan_nxt;
      fall_r   <= fall_nxt;
      flight_r <= flight_nxt;
      pend_r   <= pend_nxt;
      v_r      <= {v_r[3:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    last_r <= {last_r[3:0], in_tlast};
    if (accept) begin
      dryl_r <= in_tdata[SB-1:0];
      dryr_r <= in_tdata[2*SB-1:SB];
      wl_r   <= ssd_pkg::PAN_FULL - pan_r;
      wr_r   <= pan_r;
    end
  end

  assign ring_ctl = '{rd_en: accept, wr_en: wb};

  ssd_ring #(.AW(AW), .SB(SB)) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ring_ctl),
    .rd_addr (rd_addr),
    .wr_l    (sat_l),
    .wr_r    (sat_r),
    .rd_l    (wet_l),
    .rd_r    (wet_r)
  );

  ssd_lane #(.SB(SB)) u_lane_l (
    .clk     (clk),
    .dry_in  (dryl_r),
    .wet_in  (wet_l),
    .weight  (wl_r),
    .gain    (gain_r),
    .dry_out (dry_l4),
    .d_out   (d_l)
  );

  ssd_lane #(.SB(SB)) u_lane_r (
    .clk     (clk),
    .dry_in  (dryr_r),
    .wet_in  (wet_r),
    .weight  (wr_r),
    .gain    (gain_r),
    .dry_out (dry_r4),
    .d_out   (d_r)
  );

  ssd_merge #(.SB(SB), .DW(DW)) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (wb),
    .in_last    (last_r[4]),
    .dry_l      (dry_l4),
    .d_l        (d_l),
    .dry_r      (dry_r4),
    .d_r        (d_r),
    .sat_l      (sat_l),
    .sat_r      (sat_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* rtl/ssd_ring.sv */
// Frame history ring: one write and one registered read per cycle.
// Depends on ssd_pkg; slots never written since reset read as zero via a fill pointer.
`timescale 1ns / 1ps

module ssd_ring #(
  parameter int AW = 16,
  parameter int SB = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ssd_pkg::ring_ctl_t   ctl,
  input  logic [AW-1:0]        rd_addr,
  input  logic signed [SB-1:0] wr_l,
  input  logic signed [SB-1:0] wr_r,
  output logic signed [SB-1:0] rd_l,
  output logic signed [SB-1:0] rd_r
);

  logic [2*SB-1:0] mem_r [2**AW];
  logic [2*SB-1:0] rdata_r;
  logic [AW-1:0]   cptr_r;
  logic            full_r;
  logic            rzero_r;

  // writes land in frame order from slot zero, so everything below cptr_r
  // (or everything, once it has wrapped) holds real data
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[cptr_r] <= {wr_r, wr_l};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cptr_r  <= '0;
      full_r  <= 1'b0;
      rzero_r <= 1'b1;
    end else begin
      if (ctl.wr_en) begin
        cptr_r <= cptr_r + AW'(1);
        if (cptr_r == '1) begin
          full_r <= 1'b1;
        end
      end
      if (ctl.rd_en) begin
        rzero_r <= !(full_r || (rd_addr < cptr_r));
      end
    end
  end

  assign rd_l = rzero_r ? '0 : rdata_r[SB-1:0];
  assign rd_r = rzero_r ? '0 : rdata_r[2*SB-1:SB];

endmodule

/* rtl/ssd_lane.sv */
// One channel lane: scales the delayed sample by pan weight and delay gain.
// Depends on ssd_pkg; four register stages, divide by 6553600 as shift plus reciprocal.
`timescale 1ns / 1ps

module ssd_lane #(
  parameter int SB = 24
) (
  input  logic                   clk,
  input  logic signed [SB-1:0]   dry_in,
  input  logic signed [SB-1:0]   wet_in,
  input  ssd_pkg::weight_t       weight,
  input  logic [15:0]            gain,
  output logic signed [SB-1:0]   dry_out,
  output logic signed [SB+1:0]   d_out
);

  localparam int PW        = SB + 24;
  localparam int ZW        = PW - 16;
  localparam int DIV_SHIFT = ZW + 8;
  localparam int RW        = ZW + 3;
  localparam int QW        = ZW + RW;
  localparam int Q0W       = QW - DIV_SHIFT;
  localparam int DW        = SB + 2;
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << DIV_SHIFT) + 64'd99) / 64'd100);

  logic signed [SB+7:0] m1_r;
  logic signed [PW-1:0] x_r;
  logic signed [ZW-1:0] z;
  logic signed [ZW-1:0] z2_r;
  logic signed [QW-1:0] qm_r;
  logic signed [Q0W-1:0] q0;
  logic signed [ZW:0]   rem;
  logic signed [Q0W-1:0] qc;
  logic signed [DW-1:0] d_r;
  logic signed [SB-1:0] dry1_r, dry2_r, dry3_r, dry4_r;

  // floor(x / 2^16) is an arithmetic shift; the rest is floor(z / 100)
  assign z  = x_r[PW-1:16];
  assign q0 = qm_r[QW-1:DIV_SHIFT];

  // reciprocal estimate is off by at most one; fix it with the remainder
  always_comb begin
    rem = (ZW+1)'(z2_r) - (ZW+1)'(q0) * (ZW+1)'(ssd_pkg::DIV_BY);
    priority if (rem[ZW]) begin
      qc = q0 - Q0W'(1);
    end else if (rem >= (ZW+1)'(ssd_pkg::DIV_BY)) begin
      qc = q0 + Q0W'(1);
    end else begin
      qc = q0;
    end
  end

  always_ff @(posedge clk) begin
    m1_r   <= (SB+8)'(wet_in) * (SB+8)'(weight);
    x_r    <= PW'(m1_r) * PW'($signed({1'b0, gain})) + PW'(ssd_pkg::ROUND);
    qm_r   <= QW'(z) * QW'($signed({1'b0, RECIP}));
    z2_r   <= z;
    d_r    <= DW'(qc);
    dry1_r <= dry_in;
    dry2_r <= dry1_r;
    dry3_r <= dry2_r;
    dry4_r <= dry3_r;
  end

  assign dry_out = dry4_r;
  assign d_out   = d_r;

endmodule

/* rtl/ssd_merge.sv */
// Merge stage: adds each lane's echo to its dry sample, saturates, queues the frame.
// Depends on ssd_pkg; the saturated pair also goes back to the history ring.
`timescale 1ns / 1ps

module ssd_merge #(
  parameter int SB = 24,
  parameter int DW = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_last,
  input  logic signed [SB-1:0] dry_l,
  input  logic signed [SB+1:0] d_l,
  input  logic signed [SB-1:0] dry_r,
  input  logic signed [SB+1:0] d_r,
  output logic signed [SB-1:0] sat_l,
  output logic signed [SB-1:0] sat_r,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [DW-1:0]        out_tdata,
  output logic                 out_tlast
);

  localparam logic signed [SB+2:0] SMAX = (SB+3)'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [SB+2:0] SMIN = -SMAX - (SB+3)'(1);

  function automatic logic signed [SB-1:0] mix_sat(input logic signed [SB-1:0] a,
                                                   input logic signed [SB+1:0] b);
    logic signed [SB+2:0] s;
    s = (SB+3)'(a) + (SB+3)'(b);
    if (s > SMAX) begin
      return SMAX[SB-1:0];
    end else if (s < SMIN) begin
      return SMIN[SB-1:0];
    end
    return s[SB-1:0];
  endfunction

  logic [2*SB:0]               fifo_r [ssd_pkg::FIFO_DEPTH];
  logic [ssd_pkg::FIFO_AW-1:0] wptr_r, rptr_r;
  ssd_pkg::cnt_t               cnt_r, cnt_nxt;
  logic                        pop;
  logic [2*SB:0]               head;

  assign sat_l = mix_sat(dry_l, d_l);
  assign sat_r = mix_sat(dry_r, d_r);

  // the top level grants input credit only while the queue has room
  always_ff @(posedge clk) begin
    if (in_valid) begin
      fifo_r[wptr_r] <= {in_last, sat_r, sat_l};
    end
  end

  assign pop = out_tvalid && out_tready;

  always_comb begin
    unique case ({in_valid, pop})
      2'b10:   cnt_nxt = cnt_r + ssd_pkg::cnt_t'(1);
      2'b01:   cnt_nxt = cnt_r - ssd_pkg::cnt_t'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (in_valid) begin
        wptr_r <= wptr_r + ssd_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + ssd_pkg::FIFO_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign head       = fifo_r[rptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = DW'(head[2*SB-1:0]);
  assign out_tlast  = head[2*SB];

endmodule

/* rtl/ssd_check.sv */
// Port-level checker for stereo_sweep_delay_core, attached by the bind below.
// Depends on ssd_pkg; tracks frames taken in against frames handed out.
`timescale 1ns / 1ps

module ssd_check #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   out_tdata,
  input logic                                 out_tlast
);

  logic [4:0] pend_r;
  logic       in_x, out_x;

  assign in_x  = in_tvalid && in_tready;
  assign out_x = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 5'(in_x) - 5'(out_x);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output transfer changed while stalled");

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 5'd0)
    else $error("result offered with no frame outstanding");

  a_credit_cap: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 5'(ssd_pkg::FIFO_DEPTH))
    else $error("more frames outstanding than the output queue holds");

  a_credit_stop: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == 5'(ssd_pkg::FIFO_DEPTH) |-> !in_tready)
    else $error("input ready with output queue fully committed");

endmodule

bind stereo_sweep_delay_core ssd_check #(.SAMPLE_BITS(SAMPLE_BITS)) u_ssd_check (.*);

/* tb/tb_stereo_sweep_delay_core.sv */
// Testbench for stereo_sweep_delay_core: directed table, random phases, zero/long-delay runs.
// Results are checked against an in-bench feedback delay predictor. Depends on ssd_pkg.
`timescale 1ns / 1ps

module tb_stereo_sweep_delay_core;

  localparam int RING_FRAMES = 65536;
  localparam int SAMPLE_BITS = 24;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic signed [23:0] S_MAX = 24'sh7fffff;
  localparam logic signed [23:0] S_MIN = 24'sh800000;

  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
    logic               last;
  } frame_t;

  typedef struct {
    bit                         is_cfg;
    logic [ssd_pkg::CFG_AW-1:0] idx;
    logic [15:0]                val;
    logic signed [23:0]         left;
    logic signed [23:0]         right;
    bit                         last;
    bit                         typed;
    logic signed [23:0]         exp_left;
    logic signed [23:0]         exp_right;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // left_in, right_in
  logic        in_tlast;   // period_end
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // left_out, right_out
  logic        out_tlast;  // last_out
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [ssd_pkg::CFG_AW-1:0] cfg_index;
  logic [15:0]                cfg_data;

  stereo_sweep_delay_core #(
    .RING_FRAMES(RING_FRAMES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic signed [23:0] echo_left  [RING_FRAMES];
  logic signed [23:0] echo_right [RING_FRAMES];
  logic [15:0] echo_wpos;
  logic [15:0] tap_delay;
  logic [15:0] tap_gain;
  int          pan_pos;
  bit          pan_down;

  frame_t pending_mix[$];
  int     mismatches;
  bit     gap_on;
  bit     stall_on;
  int     stall_left;

  // expectation typed into the directed table, carried with the frame being driven
  bit                 drv_typed;
  logic signed [23:0] drv_exp_left;
  logic signed [23:0] drv_exp_right;

  row_t script[$];

  // dry + round(tap * w/100 * gain/32768 * 0.5), ties up, saturated
  function automatic logic signed [23:0] mix_channel(logic signed [23:0] dry,
                                                     logic signed [23:0] tap, int w);
    longint num;
    longint q;
    longint sum;
    num = longint'(tap) * longint'(w) * longint'({48'd0, tap_gain}) + 64'sd3276800;
    q = num / 64'sd6553600;
    if ((num % 64'sd6553600) != 0 && num < 0) q = q - 1;
    sum = longint'(dry) + q;
    if (sum > longint'(S_MAX)) return S_MAX;
    if (sum < longint'(S_MIN)) return S_MIN;
    return sum[23:0];
  endfunction

  function automatic frame_t mix_frame(logic [47:0] d, logic last);
    frame_t f;
    logic [15:0] rd;
    rd = echo_wpos - tap_delay;
    f.left  = mix_channel(d[23:0],  echo_left[rd],  100 - pan_pos);
    f.right = mix_channel(d[47:24], echo_right[rd], pan_pos);
    f.last  = last;
    echo_left[echo_wpos]  = f.left;
    echo_right[echo_wpos] = f.right;
    echo_wpos = echo_wpos + 16'd1;
    if (last) begin
      if (!pan_down) begin
        pan_pos++;
        if (pan_pos > 100) pan_down = 1'b1;
      end else begin
        pan_pos--;
        if (pan_pos < 0) pan_down = 1'b0;
      end
    end
    return f;
  endfunction

  always @(posedge clk) begin
    frame_t want;
    frame_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ssd_pkg::REG_DELAY_FRAMES: tap_delay = cfg_data;
          ssd_pkg::REG_DELAY_GAIN:   tap_gain  = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        want = mix_frame(in_tdata, in_tlast);
        if (drv_typed) begin
          want.left  = drv_exp_left;
          want.right = drv_exp_right;
        end
        pending_mix.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.left  = out_tdata[23:0];
        got.right = out_tdata[47:24];
        got.last  = out_tlast;
        if (pending_mix.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected transfer L=%0d R=%0d last=%0b",
                     $realtime, got.left, got.right, got.last);
        end else begin
          want = pending_mix.pop_front();
          if (got.left !== want.left || got.right !== want.right || got.last !== want.last)
          begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp L=%0d R=%0d last=%0b got L=%0d R=%0d last=%0b",
                       $realtime, want.left, want.right, want.last,
                       got.left, got.right, got.last);
          end
        end
      end
    end
  end

  // receiver back-pressure in random bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (rst_n && stall_on && $urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 12);
    end else begin
      out_tready <= rst_n;
    end
  end

  task automatic send_frame(input logic signed [23:0] l, input logic signed [23:0] r,
                            input bit last, input bit typed,
                            input logic signed [23:0] el, input logic signed [23:0] er);
    int n;
    if (gap_on && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 13);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid     <= 1'b1;
    in_tdata      <= {r, l};
    in_tlast      <= last;
    drv_typed     <= typed;
    drv_exp_left  <= el;
    drv_exp_right <= er;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop sending and wait out every outstanding result
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_mix.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ssd_pkg::CFG_AW-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void frame_row(logic signed [23:0] l, logic signed [23:0] r, bit last,
                                    bit typed, logic signed [23:0] el,
                                    logic signed [23:0] er);
    row_t w;
    w = '{default: '0};
    w.left = l; w.right = r; w.last = last;
    w.typed = typed; w.exp_left = el; w.exp_right = er;
    script.push_back(w);
  endfunction

  function automatic void cfg_row(logic [ssd_pkg::CFG_AW-1:0] idx, logic [15:0] val);
    row_t w;
    w = '{default: '0};
    w.is_cfg = 1'b1; w.idx = idx; w.val = val;
    script.push_back(w);
  endfunction

  function automatic logic signed [23:0] pick_sample();
    int v;
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: begin
        v = $urandom_range(0, 511) - 256;
        return v[23:0];
      end
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic random_run(input int count, input int end_odds);
    for (int i = 0; i < count; i++)
      send_frame(pick_sample(), pick_sample(), $urandom_range(0, end_odds - 1) == 0,
                 1'b0, '0, '0);
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int dly;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = ssd_pkg::REG_DELAY_FRAMES;
    cfg_data   = '0;
    drv_typed  = 1'b0;
    drv_exp_left  = '0;
    drv_exp_right = '0;
    gap_on     = 1'b1;
    stall_on   = 1'b1;
    stall_left = 0;
    mismatches = 0;
    for (int i = 0; i < RING_FRAMES; i++) begin
      echo_left[i]  = '0;
      echo_right[i] = '0;
    end
    echo_wpos = '0;
    tap_delay = 16'd1000;
    tap_gain  = 16'd16384;
    pan_pos   = 0;
    pan_down  = 1'b0;

    // after reset the ring reads zero, so frames pass straight through
    frame_row(0, 0, 0, 1, 0, 0);
    frame_row(S_MAX, S_MIN, 0, 1, S_MAX, S_MIN);
    frame_row(S_MIN, S_MAX, 0, 1, S_MIN, S_MAX);
    frame_row(-1, 1, 1, 1, -1, 1);
    frame_row(1, -1, 0, 1, 1, -1);
    frame_row(24'sh555555, -24'sh2aaaab, 1, 1, 24'sh555555, -24'sh2aaaab);
    // one-frame echo at full gain: saturates at the top
    cfg_row(ssd_pkg::REG_DELAY_FRAMES, 16'd1);
    cfg_row(ssd_pkg::REG_DELAY_GAIN, 16'hffff);
    frame_row(S_MAX, S_MAX, 0, 0, 0, 0);
    frame_row(S_MAX, S_MAX, 0, 0, 0, 0);
    frame_row(S_MIN, S_MIN, 1, 0, 0, 0);
    frame_row(0, 0, 0, 0, 0, 0);
    // zero gain and zero delay both leave the input alone
    cfg_row(ssd_pkg::REG_DELAY_FRAMES, 16'd0);
    cfg_row(ssd_pkg::REG_DELAY_GAIN, 16'd0);
    frame_row(S_MAX, S_MIN, 1, 1, S_MAX, S_MIN);
    frame_row(123456, -654321, 0, 1, 123456, -654321);
    // longest delay lands on a slot never written
    cfg_row(ssd_pkg::REG_DELAY_FRAMES, 16'hffff);
    cfg_row(ssd_pkg::REG_DELAY_GAIN, 16'd32768);
    frame_row(S_MIN, S_MAX, 0, 1, S_MIN, S_MAX);
    frame_row(7, -7, 1, 1, 7, -7);
    cfg_row(ssd_pkg::REG_DELAY_FRAMES, 16'd2);
    cfg_row(ssd_pkg::REG_DELAY_GAIN, 16'd40000);
    frame_row(S_MIN, S_MAX, 0, 0, 0, 0);
    frame_row(S_MAX, S_MIN, 0, 0, 0, 0);
    frame_row(-4000000, 4000000, 1, 0, 0, 0);
    frame_row(1, 1, 0, 0, 0, 0);
    frame_row(S_MIN, S_MIN, 0, 0, 0, 0);
    frame_row(S_MAX, S_MAX, 1, 0, 0, 0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        drain();
        write_reg(script[i].idx, script[i].val);
      end else begin
        send_frame(script[i].left, script[i].right, script[i].last, script[i].typed,
                   script[i].exp_left, script[i].exp_right);
      end
    end

    // random phases; frequent period ends sweep the pan past both ends
    for (int p = 0; p < 10; p++) begin
      drain();
      case (p % 5)
        0: dly = $urandom_range(1, 5);
        1: dly = $urandom_range(6, 8);
        2: dly = $urandom_range(9, 300);
        3: dly = $urandom_range(301, 1300);
        default: dly = 1;
      endcase
      write_reg(ssd_pkg::REG_DELAY_FRAMES, dly[15:0]);
      write_reg(ssd_pkg::REG_DELAY_GAIN, (p % 3 == 0) ? 16'hffff : 16'($urandom));
      gap_on   = $urandom_range(0, 2) != 0;
      stall_on = $urandom_range(0, 2) != 0;
      if (p == 4) begin
        random_run(55, 2);
        drain();
        random_run(55, 2);
      end else begin
        random_run(110, 2);
      end
    end

    // no idling from here on; zero delay reads the oldest slot, still empty
    drain();
    gap_on   = 1'b0;
    stall_on = 1'b0;
    write_reg(ssd_pkg::REG_DELAY_FRAMES, 16'd0);
    write_reg(ssd_pkg::REG_DELAY_GAIN, 16'd60000);
    random_run(100, 16);
    drain();
    write_reg(ssd_pkg::REG_DELAY_FRAMES, 16'hffff);
    write_reg(ssd_pkg::REG_DELAY_GAIN, 16'hffff);
    random_run(100, 16);
    drain();
    write_reg(ssd_pkg::REG_DELAY_FRAMES, 16'd30000);
    random_run(100, 16);
    drain();
    repeat (20) @(posedge clk);

    if (mismatches == 0 && pending_mix.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
